### design/cft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
// Used by the parser, the result buffer, the top level and the checker.
`default_nettype none

package cft_pkg;

   localparam logic [7:0]  BYTE_QUOTE      = 8'h22;
   localparam logic [7:0]  BYTE_LF         = 8'h0A;
   localparam logic [7:0]  BYTE_CR         = 8'h0D;
   localparam logic [7:0]  MAX_FIELD_LEN   = 8'd255;
   localparam logic [15:0] ROW_TOP         = 16'hFFFF;
   localparam logic [9:0]  COL_TOP         = 10'h3FF;
   localparam logic [7:0]  DELIMITER_RESET = 8'd44;

   // register index, taken from paddr bit 2 (registers sit 4 bytes apart)
   localparam logic        REG_DELIMITER   = 1'b0;

   localparam int unsigned RES_SLOTS = 4;
   localparam int unsigned CNT_W     = $clog2(RES_SLOTS + 1);

   typedef enum logic [2:0] {
      MODE_BUF_START   = 3'd0,
      MODE_BETWEEN     = 3'd1,
      MODE_FIELD_START = 3'd2,
      MODE_UNQUOTED    = 3'd3,
      MODE_QUOTED      = 3'd4,
      MODE_QUOTE_SEEN  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_ROW_END   = 2'd2,
      KIND_BUF_END   = 2'd3
   } kind_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  field_count;
      logic [9:0]  column_number;
      logic [15:0] row_number;
      logic        overflow_seen;
   } parse_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_value;
      logic [15:0] row_index;
      logic [9:0]  column_index;
      logic [7:0]  field_length;
      logic        truncated;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic can_load;
      logic valid;
   } buf_status_type;

endpackage

`default_nettype wire

### design/cft_parser.sv
// Combinational parse step: one byte plus parser state in, up to four results
// and the next parser state out. Depends on cft_pkg.
`default_nettype none

module cft_parser (
   input  wire logic [7:0]                                 byte_value,
   input  wire logic                                       last_byte,
   input  wire logic [7:0]                                 delimiter,
   input  wire cft_pkg::parse_state_type                   cur_state,
   output cft_pkg::parse_state_type                        nxt_state,
   output cft_pkg::result_type [cft_pkg::RES_SLOTS-1:0]    results,
   output logic [cft_pkg::CNT_W-1:0]                       res_count
);

   function automatic cft_pkg::result_type mk_res(
      input cft_pkg::kind_type k,
      input logic [7:0]        ch,
      input logic [15:0]       row,
      input logic [9:0]        col,
      input logic [7:0]        len,
      input logic              tr
   );
      cft_pkg::result_type r;
      r.kind         = k;
      r.char_value   = ch;
      r.row_index    = row;
      r.column_index = col;
      r.field_length = len;
      r.truncated    = tr;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   localparam int unsigned CNT_W_L = cft_pkg::CNT_W;

   logic                  is_eol;
   logic                  is_delim;
   logic                  is_quote;
   logic                  do_end_field;
   logic                  do_end_row;
   logic                  do_start;
   logic                  do_char;
   cft_pkg::mode_type     mode_sel;
   cft_pkg::parse_state_type st;
   logic [CNT_W_L-1:0]    n;
   logic [15:0]           rows;
   cft_pkg::result_type [cft_pkg::RES_SLOTS-1:0] res;

   assign is_eol   = (byte_value == cft_pkg::BYTE_CR) || (byte_value == cft_pkg::BYTE_LF);
   assign is_delim = (byte_value == delimiter);
   assign is_quote = (byte_value == cft_pkg::BYTE_QUOTE);

   always_comb begin
      do_end_field = 1'b0;
      do_end_row   = 1'b0;
      do_start     = 1'b0;
      do_char      = 1'b0;
      mode_sel     = cur_state.mode;

      case (cur_state.mode)
         cft_pkg::MODE_BETWEEN: begin
            do_start = !is_eol;
         end
         cft_pkg::MODE_UNQUOTED: begin
            if (is_delim) begin
               do_end_field = 1'b1;
               mode_sel     = cft_pkg::MODE_FIELD_START;
            end else if (is_eol) begin
               do_end_field = 1'b1;
               do_end_row   = 1'b1;
            end else begin
               do_char = 1'b1;
            end
         end
         cft_pkg::MODE_QUOTED: begin
            if (is_quote) mode_sel = cft_pkg::MODE_QUOTE_SEEN;
            else          do_char  = 1'b1;
         end
         cft_pkg::MODE_QUOTE_SEEN: begin
            if (is_quote) begin
               do_char  = 1'b1;
               mode_sel = cft_pkg::MODE_QUOTED;
            end else begin
               do_end_field = 1'b1;
               if (is_delim)    mode_sel   = cft_pkg::MODE_FIELD_START;
               else if (is_eol) do_end_row = 1'b1;
               else             do_start   = 1'b1;
            end
         end
         default: begin
            // buffer start and field start behave alike; unused codes too
            if (is_eol) do_end_row = 1'b1;
            else        do_start   = 1'b1;
         end
      endcase

      // open a new field: quote wins over the delimiter
      if (do_start) begin
         if (is_quote) begin
            mode_sel = cft_pkg::MODE_QUOTED;
         end else if (is_delim) begin
            do_end_field = 1'b1;
            mode_sel     = cft_pkg::MODE_FIELD_START;
         end else begin
            do_char  = 1'b1;
            mode_sel = cft_pkg::MODE_UNQUOTED;
         end
      end

      st  = cur_state;
      n   = '0;
      res = '0;

      if (do_end_field) begin
         res[n[1:0]] = mk_res(cft_pkg::KIND_FIELD_END, 8'd0, st.row_number,
                              st.column_number, st.field_count, st.overflow_seen);
         n = n + 1'b1;
         if (st.column_number < cft_pkg::COL_TOP) st.column_number = st.column_number + 1'b1;
         st.field_count   = '0;
         st.overflow_seen = 1'b0;
      end

      st.mode = mode_sel;

      if (do_end_row) begin
         res[n[1:0]] = mk_res(cft_pkg::KIND_ROW_END, 8'd0, st.row_number,
                              st.column_number, 8'd0, 1'b0);
         n = n + 1'b1;
         if (st.row_number < cft_pkg::ROW_TOP) st.row_number = st.row_number + 1'b1;
         st.column_number = '0;
         st.mode          = cft_pkg::MODE_BETWEEN;
      end

      if (do_start) begin
         st.field_count   = '0;
         st.overflow_seen = 1'b0;
      end

      if (do_char) begin
         if (st.field_count < cft_pkg::MAX_FIELD_LEN) begin
            res[n[1:0]] = mk_res(cft_pkg::KIND_CHAR, byte_value, st.row_number,
                                 st.column_number, 8'd0, 1'b0);
            n = n + 1'b1;
            st.field_count = st.field_count + 1'b1;
         end else begin
            // drop the byte, flag it on the field end
            st.overflow_seen = 1'b1;
         end
      end

      rows = st.row_number;
      if (last_byte) begin
         if (st.mode >= cft_pkg::MODE_UNQUOTED) begin
            res[n[1:0]] = mk_res(cft_pkg::KIND_FIELD_END, 8'd0, st.row_number,
                                 st.column_number, st.field_count, st.overflow_seen);
            n = n + 1'b1;
         end
         if ((st.mode >= cft_pkg::MODE_FIELD_START) && (rows < cft_pkg::ROW_TOP)) begin
            rows = rows + 1'b1;
         end
         res[n[1:0]] = mk_res(cft_pkg::KIND_BUF_END, 8'd0, rows, 10'd0, 8'd0, 1'b0);
         n = n + 1'b1;
         st.mode          = cft_pkg::MODE_BUF_START;
         st.field_count   = '0;
         st.column_number = '0;
         st.row_number    = '0;
         st.overflow_seen = 1'b0;
      end

      if (n != '0) res[2'(n - 1'b1)].last_of_run = 1'b1;

      nxt_state = st;
      results   = res;
      res_count = n;
   end

endmodule

`default_nettype wire

### design/cft_result_buf.sv
// Result buffer: holds the results of one byte and drains them one beat per
// cycle while pop is held, head in slot zero. Depends on cft_pkg.
`default_nettype none

module cft_result_buf (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      load,
   input  wire cft_pkg::result_type [cft_pkg::RES_SLOTS-1:0] load_results,
   input  wire logic [cft_pkg::CNT_W-1:0]                 load_count,
   input  wire logic                                      pop,
   output cft_pkg::result_type                            head,
   output cft_pkg::buf_status_type                        status
);

   localparam logic [cft_pkg::CNT_W-1:0] CNT_ONE = cft_pkg::CNT_W'(1);

   cft_pkg::result_type [cft_pkg::RES_SLOTS-1:0] ent_ff, ent_in;
   logic [cft_pkg::CNT_W-1:0]                    cnt_ff, cnt_in;

   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      if (load) begin
         ent_in = load_results;
         cnt_in = load_count;
      end else if (pop) begin
         // advance the queue by one slot
         for (int i = 0; i < cft_pkg::RES_SLOTS - 1; i++) begin
            ent_in[i] = ent_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign head            = ent_ff[0];
   assign status.valid    = (cnt_ff != '0);
   assign status.can_load = (cnt_ff == '0) || ((cnt_ff == CNT_ONE) && pop);

endmodule

`default_nettype wire

### design/csv_field_tokenizer_core.sv
// CSV field tokenizer top level: input register, parser state, delimiter
// register, and the result buffer. Depends on cft_pkg, cft_parser, cft_result_buf.
// A byte waits in the input register until the result buffer can take its
// results, which the buffer then presents. Throughput: one byte per cycle
// while each byte yields at most one result and rsp_tready stays high; a byte
// yielding more results holds the next byte in the input register while they
// drain. Reset (synchronous, active high): parser at buffer start, buffers empty, delimiter 44.
`default_nettype none

module csv_field_tokenizer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: byte_value[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   // rsp_tdata: char_value[7:0], row_index[23:8], column_index[33:24],
   //            field_length[41:34], truncated[42], zero[47:43]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,
   // rsp_tuser: kind[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_last_ff;
   logic [7:0]               delim_ff, delim_in;
   cft_pkg::parse_state_type state_ff, state_in, state_nxt;
   cft_pkg::result_type [cft_pkg::RES_SLOTS-1:0] results;
   logic [cft_pkg::CNT_W-1:0] res_count;
   cft_pkg::result_type      head;
   cft_pkg::buf_status_type  status;
   logic                     advance;
   logic                     pop;
   logic                     req_beat;
   logic                     csr_wr;

   assign pop        = rsp_tvalid && rsp_tready;
   assign advance    = in_valid_ff && status.can_load;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   cft_parser u_parser (
      .byte_value (in_byte_ff),
      .last_byte  (in_last_ff),
      .delimiter  (delim_ff),
      .cur_state  (state_ff),
      .nxt_state  (state_nxt),
      .results    (results),
      .res_count  (res_count)
   );

   cft_result_buf u_result_buf (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .load_results (results),
      .load_count   (res_count),
      .pop          (pop),
      .head         (head),
      .status       (status)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      state_in = advance ? state_nxt : state_ff;
   end

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign delim_in   = (csr_wr && (csr_paddr[2] == cft_pkg::REG_DELIMITER) && (csr_paddr[1:0] == 2'b00))
                       ? csr_pwdata[7:0] : delim_ff;
   assign csr_prdata = ((csr_paddr[2] == cft_pkg::REG_DELIMITER) && (csr_paddr[1:0] == 2'b00))
                       ? {24'd0, delim_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         delim_ff               <= cft_pkg::DELIMITER_RESET;
         state_ff.mode          <= cft_pkg::MODE_BUF_START;
         state_ff.field_count   <= '0;
         state_ff.column_number <= '0;
         state_ff.row_number    <= '0;
         state_ff.overflow_seen <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         delim_ff    <= delim_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = status.valid;
   assign rsp_tdata  = {5'd0, head.truncated, head.field_length, head.column_index,
                        head.row_index, head.char_value};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last_of_run;

endmodule

`default_nettype wire

### design/cft_checker.sv
// Port-level checker for the CSV field tokenizer, bound to the top level.
// Depends on cft_pkg and csv_field_tokenizer_core.
`default_nettype none

module cft_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [2:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   // a stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // a character beat carries no length or truncation flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == cft_pkg::KIND_CHAR) |-> (rsp_tdata[42:34] == 9'd0))
      else $error("character beat with field length or truncation");

   // non-character beats carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != cft_pkg::KIND_CHAR) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("non-character beat with data byte");

   // buffer end closes the run at column zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == cft_pkg::KIND_BUF_END) |-> rsp_tlast && (rsp_tdata[33:24] == 10'd0))
      else $error("buffer end not last or not at column zero");

   // a delimiter write reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr == 3'd0)
      |=> (csr_paddr != 3'd0) || (csr_prdata[7:0] == $past(csr_pwdata[7:0])))
      else $error("delimiter readback mismatch");

endmodule

bind csv_field_tokenizer_core cft_checker u_cft_checker (.*);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for csv_field_tokenizer_core: byte stream in, tokens out.
// Predicts every token from its own copy of the parser state and checks them in order.
// Depends on cft_pkg and the csv_field_tokenizer_core RTL.
module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam logic [2:0] CSR_ADDR = 3'({cft_pkg::REG_DELIMITER, 2'b00});

   typedef struct {
      logic [7:0] value;
      logic       last;
   } byte_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   csv_field_tokenizer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   byte_beat_type pending_beats[$];
   cft_pkg::result_type expected_tokens[$];
   cft_pkg::result_type run_tokens[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   // parser copy
   cft_pkg::mode_type mode_q = cft_pkg::MODE_BUF_START;
   logic [7:0]  chars_q = 8'd0;
   logic [9:0]  col_q = 10'd0;
   logic [15:0] row_q = 16'd0;
   logic        ovf_q = 1'b0;
   logic [7:0]  line_delimiter = cft_pkg::DELIMITER_RESET;

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, msg);
   endfunction

   function automatic string token_text(input cft_pkg::result_type t);
      return $sformatf("kind %0d char %02h row %0d col %0d len %0d trunc %0d last %0d",
                       t.kind, t.char_value, t.row_index, t.column_index,
                       t.field_length, t.truncated, t.last_of_run);
   endfunction

   function automatic logic is_eol(input logic [7:0] b);
      return b == cft_pkg::BYTE_CR || b == cft_pkg::BYTE_LF;
   endfunction

   function automatic void emit_token(input cft_pkg::kind_type k, input logic [7:0] ch,
                                      input logic [15:0] row, input logic [9:0] col,
                                      input logic [7:0] len, input logic tr);
      cft_pkg::result_type t;
      if (run_tokens.size() < cft_pkg::RES_SLOTS) begin
         t.kind = k;
         t.char_value = ch;
         t.row_index = row;
         t.column_index = col;
         t.field_length = len;
         t.truncated = tr;
         t.last_of_run = 1'b0;
         run_tokens.push_back(t);
      end
   endfunction

   function automatic void add_field_char(input logic [7:0] b);
      if (chars_q < cft_pkg::MAX_FIELD_LEN) begin
         emit_token(cft_pkg::KIND_CHAR, b, row_q, col_q, 8'd0, 1'b0);
         chars_q++;
      end else begin
         ovf_q = 1'b1;
      end
   endfunction

   function automatic void close_field();
      emit_token(cft_pkg::KIND_FIELD_END, 8'd0, row_q, col_q, chars_q, ovf_q);
      if (col_q < cft_pkg::COL_TOP) col_q++;
      chars_q = 8'd0;
      ovf_q = 1'b0;
   endfunction

   function automatic void close_row();
      emit_token(cft_pkg::KIND_ROW_END, 8'd0, row_q, col_q, 8'd0, 1'b0);
      if (row_q < cft_pkg::ROW_TOP) row_q++;
      col_q = 10'd0;
      mode_q = cft_pkg::MODE_BETWEEN;
   endfunction

   // b is never CR or LF here
   function automatic void open_field(input logic [7:0] b);
      chars_q = 8'd0;
      ovf_q = 1'b0;
      if (b == cft_pkg::BYTE_QUOTE) begin
         mode_q = cft_pkg::MODE_QUOTED;
      end else if (b == line_delimiter) begin
         close_field();
         mode_q = cft_pkg::MODE_FIELD_START;
      end else begin
         add_field_char(b);
         mode_q = cft_pkg::MODE_UNQUOTED;
      end
   endfunction

   function automatic void tokenize_byte(input logic [7:0] b, input logic last);
      logic [15:0] rows;
      cft_pkg::result_type t;
      run_tokens.delete();
      case (mode_q)
         cft_pkg::MODE_BETWEEN: begin
            if (!is_eol(b)) open_field(b);
         end
         cft_pkg::MODE_FIELD_START: begin
            if (is_eol(b)) close_row();
            else open_field(b);
         end
         cft_pkg::MODE_UNQUOTED: begin
            if (b == line_delimiter) begin
               close_field();
               mode_q = cft_pkg::MODE_FIELD_START;
            end else if (is_eol(b)) begin
               close_field();
               close_row();
            end else begin
               add_field_char(b);
            end
         end
         cft_pkg::MODE_QUOTED: begin
            if (b == cft_pkg::BYTE_QUOTE) mode_q = cft_pkg::MODE_QUOTE_SEEN;
            else add_field_char(b);
         end
         cft_pkg::MODE_QUOTE_SEEN: begin
            if (b == cft_pkg::BYTE_QUOTE) begin
               add_field_char(b);
               mode_q = cft_pkg::MODE_QUOTED;
            end else begin
               close_field();
               if (b == line_delimiter) mode_q = cft_pkg::MODE_FIELD_START;
               else if (is_eol(b)) close_row();
               else open_field(b);
            end
         end
         default: begin
            if (is_eol(b)) close_row();
            else open_field(b);
         end
      endcase
      if (last) begin
         rows = row_q;
         if (mode_q >= cft_pkg::MODE_UNQUOTED) close_field();
         if (mode_q >= cft_pkg::MODE_FIELD_START && rows < cft_pkg::ROW_TOP) rows++;
         emit_token(cft_pkg::KIND_BUF_END, 8'd0, rows, 10'd0, 8'd0, 1'b0);
         mode_q = cft_pkg::MODE_BUF_START;
         chars_q = 8'd0;
         col_q = 10'd0;
         row_q = 16'd0;
         ovf_q = 1'b0;
      end
      if (run_tokens.size() > 0) begin
         t = run_tokens.pop_back();
         t.last_of_run = 1'b1;
         run_tokens.push_back(t);
      end
      foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
   endfunction

   // driver: predict on each accepted beat, then present the next one
   always @(posedge clock) begin
      byte_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) tokenize_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.value;
               req_tlast <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      cft_pkg::result_type seen;
      cft_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind = cft_pkg::kind_type'(rsp_tuser);
         seen.char_value = rsp_tdata[7:0];
         seen.row_index = rsp_tdata[23:8];
         seen.column_index = rsp_tdata[33:24];
         seen.field_length = rsp_tdata[41:34];
         seen.truncated = rsp_tdata[42];
         seen.last_of_run = rsp_tlast;
         if (expected_tokens.size() == 0) begin
            note_mismatch($sformatf("unexpected result: %s", token_text(seen)));
         end else begin
            want = expected_tokens.pop_front();
            if (seen.kind !== want.kind || seen.char_value !== want.char_value ||
                seen.row_index !== want.row_index ||
                seen.column_index !== want.column_index ||
                seen.field_length !== want.field_length ||
                seen.truncated !== want.truncated ||
                seen.last_of_run !== want.last_of_run || rsp_tdata[47:43] !== 5'd0)
               note_mismatch($sformatf("expected %s, got %s pad %h", token_text(want),
                                       token_text(seen), rsp_tdata[47:43]));
         end
      end
   end

   // watchdog: count cycles with work outstanding and no beat moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_beats.size() == 0 && !req_tvalid && expected_tokens.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void push_beat(input logic [7:0] v, input logic last);
      byte_beat_type b;
      b.value = v;
      b.last = last;
      pending_beats.push_back(b);
   endfunction

   function automatic void push_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++)
         push_beat(s[i], last_at_end && (i == s.len() - 1));
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(255));
      while (v == line_delimiter || v == cft_pkg::BYTE_QUOTE || is_eol(v));
      return v;
   endfunction

   // one buffer of random rows and fields, mostly well-formed, last flag on its final byte
   function automatic void push_buffer();
      int start;
      int rows;
      int fields;
      int len;
      byte_beat_type tail;
      start = pending_beats.size();
      rows = $urandom_range(3, 1);
      for (int r = 0; r < rows; r++) begin
         fields = $urandom_range(4, 1);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) push_beat(line_delimiter, 1'b0);
            len = $urandom_range(5, 0);
            if ($urandom_range(9) < 3) begin
               push_beat(cft_pkg::BYTE_QUOTE, 1'b0);
               repeat (len) begin
                  case ($urandom_range(9))
                     0: begin
                        push_beat(cft_pkg::BYTE_QUOTE, 1'b0);
                        push_beat(cft_pkg::BYTE_QUOTE, 1'b0);
                     end
                     1: push_beat(line_delimiter, 1'b0);
                     2: push_beat($urandom_range(1) ? cft_pkg::BYTE_CR : cft_pkg::BYTE_LF,
                                  1'b0);
                     default: push_beat(plain_byte(), 1'b0);
                  endcase
               end
               push_beat(cft_pkg::BYTE_QUOTE, 1'b0);
               // stray byte right after the closing quote
               if ($urandom_range(9) == 0) push_beat(plain_byte(), 1'b0);
            end else begin
               repeat (len) push_beat(plain_byte(), 1'b0);
            end
         end
         if (r < rows - 1 || $urandom_range(1)) begin
            if ($urandom_range(4) == 0) push_beat(line_delimiter, 1'b0);
            case ($urandom_range(3))
               0: push_beat(cft_pkg::BYTE_LF, 1'b0);
               1: begin
                  push_beat(cft_pkg::BYTE_CR, 1'b0);
                  push_beat(cft_pkg::BYTE_LF, 1'b0);
               end
               2: push_beat(cft_pkg::BYTE_CR, 1'b0);
               default: begin
                  push_beat(cft_pkg::BYTE_LF, 1'b0);
                  push_beat(cft_pkg::BYTE_LF, 1'b0);
               end
            endcase
         end
      end
      if (pending_beats.size() == start) push_beat(plain_byte(), 1'b0);
      tail = pending_beats.pop_back();
      tail.last = 1'b1;
      pending_beats.push_back(tail);
   endfunction

   function automatic void fill_random(input int count);
      int start;
      start = pending_beats.size();
      while (pending_beats.size() - start < count) begin
         if ($urandom_range(9) < 2) begin
            repeat ($urandom_range(8, 1))
               push_beat(8'($urandom_range(255)), $urandom_range(9) == 0);
         end else begin
            push_buffer();
         end
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || expected_tokens.size() != 0);
      // let bytes that gave no token clear the pipeline
      repeat (8) @(negedge clock);
   endtask

   task automatic begin_phase(input logic [7:0] delim, input int send_pct, input int recv_pct);
      logic [31:0] readback;
      wait_drained();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR;
      csr_pwdata <= {24'($urandom), delim};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      line_delimiter = delim;
      // read back: new setup cycle, then access
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      readback = csr_prdata;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {24'd0, delim})
         note_mismatch($sformatf("delimiter readback %h, expected %h", readback, delim));
      @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      begin_phase(cft_pkg::DELIMITER_RESET, 0, 0);
      push_text("\015\n", 1'b0);
      push_text("ab,,\"c,\"\"\n\"x,\015", 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_text(",", 1'b1);
      push_text("\"", 1'b1);
      push_text("k\n", 1'b1);
      push_text("\"p\"q", 1'b1);

      begin_phase(8'd9, 79, 0);
      fill_random(20);
      begin_phase(8'd0, 0, 79);
      fill_random(20);
      begin_phase(8'd255, 35, 35);
      fill_random(20);
      begin_phase(cft_pkg::BYTE_QUOTE, 0, 0);
      fill_random(20);
      begin_phase(cft_pkg::BYTE_CR, 79, 0);
      fill_random(20);
      begin_phase(cft_pkg::BYTE_LF, 0, 79);
      fill_random(20);
      begin_phase(8'($urandom_range(255)), 35, 35);
      fill_random(20);
      begin_phase(cft_pkg::DELIMITER_RESET, 35, 35);
      fill_random(20);

      wait_drained();
      if (mismatch_count == 0 && expected_tokens.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
